[design/ubsf_pkg.sv]
`default_nettype none

package ubsf_pkg;

  // Width of a block size in words (12-bit byte count divided by four).
  localparam int unsigned WordBits = 10;

  // Header/trailer and PLOAM lengths in words.
  localparam int unsigned HdrTrlWords = 2;
  localparam int unsigned PloamWords  = 12;

  localparam int unsigned FinalBits = 18;
  localparam int unsigned OutBits   = 16;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFecEnable   = 3'd0,
    CfgGuardTime   = 3'd1,
    CfgPreambleDel = 3'd2,
    CfgDataBlock   = 3'd3,
    CfgFecBlock    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        fec_enable;
    logic [15:0] guard_time_words;
    logic [15:0] preamble_delimiter_bytes;
    logic [11:0] data_block_bytes;
    logic [11:0] fec_block_bytes;
  } cfg_t;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StDiv,
    StMul,
    StSum
  } state_e;

endpackage

`default_nettype wire

[design/upstream_burst_size_fec_unit.sv]
`default_nettype none

// Each item passes through start, the bit-serial divide that splits the
// payload into FEC blocks, the multiply and the sum; no new item is taken
// before it leaves the sum state. A result waiting in the output register
// delays only the next item's exit from the sum state, not its acceptance.
// Reset (async, active low) clears the payload count and the control state
// and restores the register defaults.
module upstream_burst_size_fec_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [ubsf_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  wire logic [ubsf_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 cmd_i,
  input  wire logic                                 ploam_present_i,
  input  wire logic [15:0]                          grant_words_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [15:0]                               payload_words_o,
  output logic [17:0]                               final_burst_words_o
);
  import ubsf_pkg::*;

  localparam int unsigned ProdW = COUNT_BITS + WordBits;
  localparam int unsigned TotW  = COUNT_BITS + 12;
  localparam logic [31:0] CountMax = (32'd1 << COUNT_BITS) - 32'd1;
  localparam logic [31:0] Out16Max = 32'd65535;
  localparam logic [TotW-1:0] FinalMax = TotW'(262143);

  cfg_t cfg;

  state_e state_q, state_d;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutBits-1:0]    payload_q, payload_d;
  logic [FinalBits-1:0]  final_q, final_d;

  logic                  in_accept;
  logic                  out_free;
  logic [31:0]           grant_sum;
  logic [31:0]           count_ext;
  logic                  div_start;
  logic                  div_busy;
  logic [COUNT_BITS-1:0] quo;
  logic [WordBits-1:0]   rem;
  logic [WordBits-1:0]   dw, fw, parity;
  logic [WordBits:0]     tail;
  logic                  fec_on;
  logic [TotW-1:0]       body, total;

  ubsf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign dw     = cfg.data_block_bytes[11:2];
  assign fw     = cfg.fec_block_bytes[11:2];
  assign parity = (fw > dw) ? (fw - dw) : '0;
  assign fec_on = cfg.fec_enable && (dw != '0);

  ubsf_div #(
    .N (COUNT_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (count_q),
    .divisor_i   (dw),
    .busy_o      (div_busy),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign payload_words_o     = payload_q;
  assign final_burst_words_o = final_q;

  assign grant_sum = 32'(count_q) + 32'(grant_words_i);
  assign count_ext = 32'(count_q);

  // Partial last block keeps its words plus a whole parity.
  assign tail  = (rem != '0) ? ({1'b0, rem} + {1'b0, parity}) : '0;
  assign body  = fec_on ? (TotW'(prod_q) + TotW'(tail)) : TotW'(count_q);
  assign total = body + TotW'(cfg.guard_time_words)
               + TotW'(cfg.preamble_delimiter_bytes[15:2]);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    payload_d   = payload_q;
    final_d     = final_q;
    div_start   = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (!cmd_i) begin
            count_d = COUNT_BITS'(ploam_present_i ? (HdrTrlWords + PloamWords)
                                                  : HdrTrlWords);
          end else begin
            count_d = (grant_sum > CountMax) ? COUNT_BITS'(CountMax)
                                             : grant_sum[COUNT_BITS-1:0];
          end
          state_d = StStart;
        end
      end
      StStart: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (!div_busy) begin
          state_d = StMul;
        end
      end
      StMul: begin
        prod_d  = ProdW'(quo) * ProdW'(fw);
        state_d = StSum;
      end
      StSum: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          payload_d   = (count_ext > Out16Max) ? OutBits'(Out16Max)
                                               : count_ext[OutBits-1:0];
          final_d     = (total > FinalMax) ? FinalBits'(FinalMax)
                                           : total[FinalBits-1:0];
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    payload_q <= payload_d;
    final_q   <= final_d;
  end

`ifndef NO_ASSERTIONS
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == StDiv))
    else $error("divider running outside the divide phase");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StStart))
    else $error("accepted transaction did not start the sequence");

  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StSum))
    else $error("result raised outside the final phase");

  a_mul_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> !div_busy)
    else $error("product taken before the quotient settled");
`endif

endmodule

`default_nettype wire

[design/ubsf_cfg.sv]
`default_nettype none

module ubsf_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [ubsf_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  wire logic [ubsf_pkg::CfgDataBits-1:0]     cfg_data_i,
  output ubsf_pkg::cfg_t                            cfg_o
);
  import ubsf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgFecEnable:   cfg_d.fec_enable               = cfg_data_i[0];
        CfgGuardTime:   cfg_d.guard_time_words         = cfg_data_i;
        CfgPreambleDel: cfg_d.preamble_delimiter_bytes = cfg_data_i;
        CfgDataBlock:   cfg_d.data_block_bytes         = cfg_data_i[11:0];
        CfgFecBlock:    cfg_d.fec_block_bytes          = cfg_data_i[11:0];
        default:        cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fec_enable               <= 1'b1;
      cfg_q.guard_time_words         <= 16'd16;
      cfg_q.preamble_delimiter_bytes <= 16'd168;
      cfg_q.data_block_bytes         <= 12'd216;
      cfg_q.fec_block_bytes          <= 12'd248;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[design/ubsf_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ubsf_div #(
  parameter int unsigned N = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [N-1:0]                       dividend_i,
  input  wire logic [ubsf_pkg::WordBits-1:0]      divisor_i,
  output logic                                    busy_o,
  output logic [N-1:0]                            quotient_o,
  output logic [ubsf_pkg::WordBits-1:0]           remainder_o
);
  import ubsf_pkg::*;

  localparam int unsigned CntW = $clog2(N + 1);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [N-1:0]        quo_q, quo_d;
  logic [WordBits-1:0] rem_q, rem_d;
  logic [WordBits:0]   trial;
  logic                fits;

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // Partial remainder shifted left with the next dividend bit.
  assign trial = {rem_q, quo_q[N-1]};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CntW'(N);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (busy_o) begin
      cnt_d = cnt_q - CntW'(1);
      quo_d = {quo_q[N-2:0], fits};
      rem_d = fits ? WordBits'(trial - {1'b0, divisor_i}) : trial[WordBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

endmodule

`default_nettype wire

[bench/burst_tb_pkg.sv]
package burst_tb_pkg;

  // Item opcodes on cmd_i.
  localparam logic CmdStart = 1'b0;
  localparam logic CmdGrant = 1'b1;

  // Percent style idle mixes for the two channels.
  typedef enum logic [1:0] {
    MixSlowSink,
    MixSlowSource,
    MixNoIdle
  } idle_mix_e;

endpackage

[bench/burst_length_checker.sv]
module burst_length_checker #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [ubsf_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [ubsf_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic                             ploam_present_i,
  input  logic [15:0]                      grant_words_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic [15:0]                      payload_words_o,
  input  logic [17:0]                      final_burst_words_o,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ubsf_pkg::*;
  import burst_tb_pkg::*;

  localparam longint unsigned CountMax    = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned OutMax      = (64'd1 << OutBits) - 64'd1;
  localparam longint unsigned FinalMax    = (64'd1 << FinalBits) - 64'd1;
  localparam int unsigned     BytesPerWord = 4;

  typedef struct packed {
    logic [15:0] payload_words;
    logic [17:0] final_words;
  } burst_len_t;

  cfg_t                    fec_cfg;
  logic [COUNT_BITS-1:0]   burst_count;
  burst_len_t              burst_len_q[$];
  int                      mismatches;
  int                      outstanding;
  int                      checked;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;
  assign checked_o    = checked;

  // Final burst length for a given payload under the current register set.
  function automatic logic [17:0] burst_length_of(longint unsigned payload);
    longint unsigned body;
    longint unsigned total;
    longint unsigned parity;
    int unsigned     dw;
    int unsigned     fw;
    dw   = fec_cfg.data_block_bytes / BytesPerWord;
    fw   = fec_cfg.fec_block_bytes / BytesPerWord;
    body = payload;
    if (fec_cfg.fec_enable && dw != 0) begin
      parity = (fw > dw) ? longint'(fw - dw) : 0;
      body   = (payload / dw) * fw;
      if (payload % dw != 0) begin
        body += (payload % dw) + parity;
      end
    end
    total = body + fec_cfg.guard_time_words + fec_cfg.preamble_delimiter_bytes / BytesPerWord;
    if (total > FinalMax) begin
      total = FinalMax;
    end
    return total[17:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint unsigned sum;
    burst_len_t      want;
    if (!rst_ni) begin
      fec_cfg.fec_enable               = 1'b1;
      fec_cfg.guard_time_words         = 16'd16;
      fec_cfg.preamble_delimiter_bytes = 16'd168;
      fec_cfg.data_block_bytes         = 12'd216;
      fec_cfg.fec_block_bytes          = 12'd248;
      burst_count = '0;
      burst_len_q.delete();
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgFecEnable:   fec_cfg.fec_enable               = cfg_data_i[0];
          CfgGuardTime:   fec_cfg.guard_time_words         = cfg_data_i;
          CfgPreambleDel: fec_cfg.preamble_delimiter_bytes = cfg_data_i;
          CfgDataBlock:   fec_cfg.data_block_bytes         = cfg_data_i[11:0];
          CfgFecBlock:    fec_cfg.fec_block_bytes          = cfg_data_i[11:0];
          default: ;  // unmapped index, dropped
        endcase
      end

      // Retire the older result before queuing a new one.
      if (out_valid_o && !out_stall_i) begin
        checked++;
        if (burst_len_q.size() == 0) begin
          $error("unexpected result: payload_words %0d, final_burst_words %0d",
                 payload_words_o, final_burst_words_o);
          mismatches++;
        end else begin
          want = burst_len_q.pop_front();
          outstanding--;
          if (payload_words_o !== want.payload_words) begin
            $error("payload_words: expected %0d, actual %0d",
                   want.payload_words, payload_words_o);
            mismatches++;
          end
          if (final_burst_words_o !== want.final_words) begin
            $error("final_burst_words: expected %0d, actual %0d",
                   want.final_words, final_burst_words_o);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        if (cmd_i == CmdStart) begin
          sum = longint'(HdrTrlWords + (ploam_present_i ? PloamWords : 0));
        end else begin
          sum = longint'(burst_count) + grant_words_i;
        end
        burst_count = (sum > CountMax) ? CountMax[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
        want.payload_words = (burst_count > OutMax) ? OutMax[15:0] : 16'(burst_count);
        want.final_words   = burst_length_of(burst_count);
        burst_len_q = {burst_len_q, want};
        outstanding++;
      end
    end
  end

endmodule

[bench/upstream_burst_size_fec_unit_tb.sv]
module upstream_burst_size_fec_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ubsf_pkg::*;
  import burst_tb_pkg::*;

  localparam int unsigned NumPhases     = 12;
  localparam int unsigned ItemsPerPhase = 108;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned LimitCycles   = 400000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   cmd_i;
  logic                   ploam_present_i;
  logic [15:0]            grant_words_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [15:0]            payload_words_o;
  logic [17:0]            final_burst_words_o;
  int                     fail_count_o;
  int                     pending_o;
  int                     checked_o;

  idle_mix_e idle_mix;
  int        hold_seq;
  int        items_sent;
  int        starts_sent;

  upstream_burst_size_fec_unit uut (.*);

  burst_length_checker checker_inst (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still pending", LimitCycles, pending_o);
    $display("FAILED: results differ");
    $finish;
  end

  // Output side: random stall per idle mix, plus long hold-offs on request.
  initial begin
    int unsigned hold_left;
    int          seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= $urandom_range(0, 99) <
                       (idle_mix == MixSlowSink ? 71 : idle_mix == MixSlowSource ? 38 : 0);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic ploam, input logic [15:0] grant);
    logic taken;
    while ($urandom_range(0, 99) <
           (idle_mix == MixSlowSink ? 38 : idle_mix == MixSlowSource ? 71 : 0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    ploam_present_i <= ploam;
    grant_words_i   <= grant;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    items_sent++;
    if (cmd == CmdStart) begin
      starts_sent++;
    end
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] value);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_o != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] fec_en, guard, pre, dblk, fblk;
    logic [15:0] grant;
    int          sent;
    int unsigned pick;
    int unsigned burst_len;
    bit          held;
    bit          paused;

    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CfgFecEnable;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    cmd_i           <= CmdStart;
    ploam_present_i <= 1'b0;
    grant_words_i   <= '0;
    rst_ni          <= 1'b0;
    idle_mix    = MixSlowSink;
    hold_seq    = 0;
    items_sent  = 0;
    starts_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under reset register values.
    send_item(CmdGrant, 1'b1, 16'd100);      // grant with no burst open
    send_item(CmdStart, 1'b0, 16'hFFFF);
    send_item(CmdGrant, 1'b0, 16'd0);
    send_item(CmdGrant, 1'b0, 16'd53);       // one full block plus a word
    send_item(CmdGrant, 1'b0, 16'd53);       // exactly two blocks
    send_item(CmdStart, 1'b1, 16'd0);
    send_item(CmdGrant, 1'b1, 16'hFFFF);     // count saturates
    send_item(CmdGrant, 1'b0, 16'd1);
    send_item(CmdStart, 1'b1, 16'hAAAA);
    send_item(CmdGrant, 1'b0, 16'h5555);
    send_item(CmdGrant, 1'b1, 16'hAAAA);
    send_item(CmdStart, 1'b0, 16'h5555);
    wait_drained();

    for (int phase = 0; phase < NumPhases; phase++) begin
      idle_mix = phase < 4 ? MixSlowSink : phase < 8 ? MixSlowSource : MixNoIdle;
      case (phase)
        0: begin  // one-word blocks, max codeword: final length saturates
          fec_en = 1; guard = 0; pre = 0; dblk = 4; fblk = 4095;
        end
        1: begin  // FEC off, max overhead
          fec_en = 0; guard = 16'hFFFF; pre = 16'hFFFF; dblk = 216; fblk = 248;
        end
        2: begin  // data block below one word disables expansion
          fec_en = 1; guard = 16; pre = 168; dblk = 3; fblk = 248;
        end
        3: begin  // codeword shorter than data block
          fec_en = 1; guard = 8; pre = 7; dblk = 4095; fblk = 4;
        end
        4: begin  // upper bits beyond register width must be dropped
          fec_en = 16'hFFFE; guard = 12; pre = 100; dblk = 16'hF0D8; fblk = 16'hF0F8;
        end
        5: begin
          fec_en = 1; guard = 16; pre = 168; dblk = 216; fblk = 248;
        end
        default: begin
          fec_en = 16'($urandom_range(0, 65535));
          guard  = 16'($urandom_range(0, 65535));
          pre    = 16'($urandom_range(0, 65535));
          dblk   = 16'($urandom_range(0, 65535));
          fblk   = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CfgFecEnable, fec_en);
      write_reg(CfgGuardTime, guard);
      write_reg(CfgPreambleDel, pre);
      write_reg(CfgDataBlock, dblk);
      write_reg(CfgFecBlock, fblk);
      for (int idx = int'(CfgFecBlock) + 1; idx < (1 << CfgIdxBits); idx++) begin
        write_reg(CfgIdxBits'(idx), CfgDataBits'($urandom_range(0, 65535)));
      end
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);

      sent   = 0;
      held   = 0;
      paused = 0;
      while (sent < ItemsPerPhase) begin
        if ((phase == 1 || phase == 6 || phase == 10) && sent >= 30 && !held) begin
          hold_seq <= hold_seq + 1;
          held = 1;
        end
        if (phase == 9 && sent >= 50 && !paused) begin
          wait_drained();
          paused = 1;
        end
        if ($urandom_range(0, 9) != 0) begin
          // well-formed burst: start then a handful of grants
          send_item(CmdStart, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
          sent++;
          burst_len = $urandom_range(1, 8);
          repeat (burst_len) begin
            pick  = $urandom_range(0, 9);
            grant = 16'(pick < 7 ? $urandom_range(0, 600) :
                        pick < 9 ? $urandom_range(0, 8000) : $urandom_range(0, 65535));
            send_item(CmdGrant, 1'($urandom_range(0, 1)), grant);
            sent++;
          end
        end else begin
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)));
          sent++;
        end
      end
      wait_drained();
    end

    $display("Run covered %0d items (%0d burst starts), %0d results checked,",
             items_sent, starts_sent, checked_o);
    $display("%0d register sets, three idle mixes on both channels and long output hold-offs.",
             NumPhases + 1);
    if (fail_count_o == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
